FILE: rtl/qtf_pkg.sv
// qtf_pkg: constants, state type, angle table and roll shift for the quaternion tilt filter
// used by quaternion_tilt_filter_unit; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package qtf_pkg;

  // cordic iteration count, range 8 to 24
  localparam int CORDIC_STEPS = 16;

  // angle scale: degrees times 128
  localparam int DEG180 = 23040;
  localparam int DEG360 = 46080;
  localparam logic signed [15:0] DEG90_Q7 = 16'sd11520;
  // cordic accumulator scale: degrees times 65536
  localparam logic signed [25:0] DEG90_Q16 = 26'sd5898240;

  localparam logic signed [39:0] ONE_Q28 = 40'sd268435456;
  localparam logic signed [17:0] RAD_SCALE = 18'sd73204;
  localparam logic [16:0] GAIN_RESET = 17'd6554;

  // iterative unit lengths
  localparam int MUL_SLOTS = 13;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS = 46;
  localparam int FILT_SLOTS = 4;

  // product slots
  localparam int P_WX = 0;
  localparam int P_YZ = 1;
  localparam int P_XX = 2;
  localparam int P_YY = 3;
  localparam int P_WZ = 4;
  localparam int P_XY = 5;
  localparam int P_ZZ = 6;
  localparam int P_WY = 7;
  localparam int P_ZX = 8;
  localparam int P_WW = 9;
  localparam int P_SQ_HH = 10;
  localparam int P_SQ_HL = 11;
  localparam int P_SQ_LL = 12;

  // jobs of the shared units
  localparam logic [1:0] JOB_PITCH = 2'd0;
  localparam logic [1:0] JOB_YAW = 2'd1;
  localparam logic [1:0] JOB_ROLL = 2'd2;
  localparam logic [1:0] JOB_SWX = 2'd0;
  localparam logic [1:0] JOB_SWY = 2'd1;
  localparam logic [1:0] JOB_ASIN = 2'd0;
  localparam logic [1:0] JOB_NORM = 2'd1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MUL   = 13'b0000000000010,
    S_CINIT = 13'b0000000000100,
    S_CORD  = 13'b0000000001000,
    S_CEND  = 13'b0000000010000,
    S_ASIN  = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_SWING = 13'b0000010000000,
    S_DINIT = 13'b0000100000000,
    S_DIV   = 13'b0001000000000,
    S_DEND  = 13'b0010000000000,
    S_FILT  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  // atan(2^-i) in degrees times 65536
  function automatic logic signed [25:0] atan_tab(input logic [4:0] i);
    logic signed [25:0] v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // add 180 degrees for the upside-down mount, wrap above 180
  function automatic logic signed [15:0] roll_shift(input logic signed [15:0] a);
    logic signed [17:0] t;
    t = 18'(a) + 18'(DEG180);
    if (t > 18'(DEG180)) begin
      t = t - 18'(DEG360);
    end
    return 16'(t);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quaternion_tilt_filter_unit.sv
// quaternion_tilt_filter_unit: euler angles, pitch/roll low-pass and swing from one quaternion
// work per request: the shared cordic, up to two 31-step square roots and up to two 46-step
//   divides; saturated sine skips a root and the roll cordic, tiny twist a root and the divides
// throughput: one request at a time; the next is taken once the result is in the output register
// reset: synchronous active low; clears state, filter memory and output valid, gain to 6554
`timescale 1ns / 1ps
`default_nettype none

module quaternion_tilt_filter_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic signed [15:0] in_quat_x,
  input  wire logic signed [15:0] in_quat_y,
  input  wire logic signed [15:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_pitch_deg,
  output logic signed [15:0]      out_roll_deg,
  output logic signed [15:0]      out_yaw_deg,
  output logic signed [15:0]      out_pitch_smoothed_deg,
  output logic signed [15:0]      out_roll_smoothed_deg,
  output logic signed [15:0]      out_pitch_smoothed_rad,
  output logic signed [15:0]      out_roll_smoothed_rad,
  output logic signed [15:0]      out_swing_w,
  output logic signed [15:0]      out_swing_x,
  output logic signed [15:0]      out_swing_y,
  output logic                    out_swing_degenerate,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [16:0]        cfg_filter_gain
);

  qtf_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r;
  logic [1:0] job_r;

  logic signed [15:0] qw_r, qx_r, qy_r, qz_r;
  logic signed [31:0] prod_r [0:9];
  logic [56:0] sq_r;

  logic signed [39:0] cx_r, cy_r;
  logic signed [25:0] acc_r;
  logic czero_r;
  logic signed [15:0] ax_r, ay_r, az_r;

  logic [61:0] sqv_r;
  logic [60:0] sqres_r;
  logic [60:0] sqbit_r;

  logic [29:0] rem_r;
  logic [45:0] dvd_r;
  logic dneg_r;

  logic signed [15:0] sw_r, sx_r, sy_r;
  logic degen_r;
  logic [16:0] gain_r;
  logic signed [15:0] sp_r, sr_r, prad_r, rrad_r;
  logic out_valid_r;

  // sine term of the y rotation
  logic signed [39:0] s_q;
  logic [39:0] s_abs;
  logic asin_hi, asin_lo;
  assign s_q = (40'(prod_r[qtf_pkg::P_WY]) - 40'(prod_r[qtf_pkg::P_ZX])) <<< 1;
  assign s_abs = s_q[39] ? 40'(-s_q) : 40'(s_q);
  assign asin_hi = s_q >= qtf_pkg::ONE_Q28;
  assign asin_lo = s_q <= -qtf_pkg::ONE_Q28;

  // twist norm squared
  logic signed [32:0] tw_sum;
  logic degen;
  assign tw_sum = 33'(prod_r[qtf_pkg::P_WW]) + 33'(prod_r[qtf_pkg::P_ZZ]);
  assign degen = tw_sum <= 33'sd2;

  // filter differences, wrapped once
  logic signed [16:0] dp_raw, dr_raw;
  logic signed [15:0] dp, dr;
  assign dp_raw = 17'(ax_r) - 17'(sp_r);
  assign dr_raw = 17'(ay_r) - 17'(sr_r);
  always_comb begin
    dp = 16'(dp_raw);
    if (dp_raw > 17'(qtf_pkg::DEG180)) dp = 16'(dp_raw - 17'(qtf_pkg::DEG360));
    else if (dp_raw < -17'(qtf_pkg::DEG180)) dp = 16'(dp_raw + 17'(qtf_pkg::DEG360));
    dr = 16'(dr_raw);
    if (dr_raw > 17'(qtf_pkg::DEG180)) dr = 16'(dr_raw - 17'(qtf_pkg::DEG360));
    else if (dr_raw < -17'(qtf_pkg::DEG180)) dr = 16'(dr_raw + 17'(qtf_pkg::DEG360));
  end

  // shared multiplier operand select
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == qtf_pkg::S_MUL) begin
      unique case (cnt_r)
        6'(qtf_pkg::P_WX): begin mul_a = 18'(qw_r); mul_b = 18'(qx_r); end
        6'(qtf_pkg::P_YZ): begin mul_a = 18'(qy_r); mul_b = 18'(qz_r); end
        6'(qtf_pkg::P_XX): begin mul_a = 18'(qx_r); mul_b = 18'(qx_r); end
        6'(qtf_pkg::P_YY): begin mul_a = 18'(qy_r); mul_b = 18'(qy_r); end
        6'(qtf_pkg::P_WZ): begin mul_a = 18'(qw_r); mul_b = 18'(qz_r); end
        6'(qtf_pkg::P_XY): begin mul_a = 18'(qx_r); mul_b = 18'(qy_r); end
        6'(qtf_pkg::P_ZZ): begin mul_a = 18'(qz_r); mul_b = 18'(qz_r); end
        6'(qtf_pkg::P_WY): begin mul_a = 18'(qw_r); mul_b = 18'(qy_r); end
        6'(qtf_pkg::P_ZX): begin mul_a = 18'(qz_r); mul_b = 18'(qx_r); end
        6'(qtf_pkg::P_WW): begin mul_a = 18'(qw_r); mul_b = 18'(qw_r); end
        6'(qtf_pkg::P_SQ_HH): begin
          mul_a = $signed({4'b0000, s_abs[27:14]});
          mul_b = $signed({4'b0000, s_abs[27:14]});
        end
        6'(qtf_pkg::P_SQ_HL): begin
          mul_a = $signed({4'b0000, s_abs[27:14]});
          mul_b = $signed({4'b0000, s_abs[13:0]});
        end
        6'(qtf_pkg::P_SQ_LL): begin
          mul_a = $signed({4'b0000, s_abs[13:0]});
          mul_b = $signed({4'b0000, s_abs[13:0]});
        end
        default: ;
      endcase
    end else if (state_r == qtf_pkg::S_FILT) begin
      unique case (cnt_r)
        6'd0: begin mul_a = $signed({1'b0, gain_r}); mul_b = 18'(dp); end
        6'd1: begin mul_a = $signed({1'b0, gain_r}); mul_b = 18'(dr); end
        6'd2: begin mul_a = 18'(sp_r); mul_b = qtf_pkg::RAD_SCALE; end
        6'd3: begin mul_a = 18'(sr_r); mul_b = qtf_pkg::RAD_SCALE; end
        default: ;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // rounding of the product, filter step and wrap
  logic signed [35:0] fround;
  logic signed [19:0] fstep, fbase, fsum;
  logic signed [15:0] fwrap;
  assign fround = mul_p + 36'sd32768;
  assign fstep = $signed(fround[35:16]);
  assign fbase = (cnt_r == 6'd0) ? 20'(sp_r) : 20'(sr_r);
  assign fsum = fbase + fstep;
  always_comb begin
    fwrap = 16'(fsum);
    if (fsum > 20'(qtf_pkg::DEG180)) fwrap = 16'(fsum - 20'(qtf_pkg::DEG360));
    else if (fsum < -20'(qtf_pkg::DEG180)) fwrap = 16'(fsum + 20'(qtf_pkg::DEG360));
  end

  // cordic vector select and quadrant fold
  logic signed [39:0] cin_x, cin_y, cinit_x, cinit_y;
  logic signed [25:0] cinit_acc;
  always_comb begin
    unique case (job_r)
      qtf_pkg::JOB_PITCH: begin
        cin_y = (40'(prod_r[qtf_pkg::P_WX]) + 40'(prod_r[qtf_pkg::P_YZ])) <<< 1;
        cin_x = qtf_pkg::ONE_Q28 -
                ((40'(prod_r[qtf_pkg::P_XX]) + 40'(prod_r[qtf_pkg::P_YY])) <<< 1);
      end
      qtf_pkg::JOB_YAW: begin
        cin_y = (40'(prod_r[qtf_pkg::P_WZ]) + 40'(prod_r[qtf_pkg::P_XY])) <<< 1;
        cin_x = qtf_pkg::ONE_Q28 -
                ((40'(prod_r[qtf_pkg::P_YY]) + 40'(prod_r[qtf_pkg::P_ZZ])) <<< 1);
      end
      default: begin
        cin_y = s_q;
        cin_x = $signed({9'b0, sqres_r[30:0]});
      end
    endcase
    cinit_x = cin_x;
    cinit_y = cin_y;
    cinit_acc = '0;
    if (cin_x < 40'sd0) begin
      if (cin_y >= 40'sd0) begin
        cinit_x = cin_y;
        cinit_y = -cin_x;
        cinit_acc = qtf_pkg::DEG90_Q16;
      end else begin
        cinit_x = -cin_y;
        cinit_y = cin_x;
        cinit_acc = -qtf_pkg::DEG90_Q16;
      end
    end
  end

  // one cordic micro-rotation
  logic signed [39:0] cdx, cdy;
  logic signed [25:0] ctab;
  assign cdx = cy_r >>> cnt_r[4:0];
  assign cdy = cx_r >>> cnt_r[4:0];
  assign ctab = qtf_pkg::atan_tab(cnt_r[4:0]);

  // final angle rounding and clamp
  logic signed [25:0] arnd;
  logic signed [15:0] angle;
  always_comb begin
    arnd = (acc_r + 26'sd256) >>> 9;
    if (arnd > 26'(qtf_pkg::DEG180)) arnd = 26'(qtf_pkg::DEG180);
    else if (arnd < -26'(qtf_pkg::DEG180)) arnd = -26'(qtf_pkg::DEG180);
    angle = czero_r ? 16'sd0 : 16'(arnd);
  end

  // one square root step
  logic [61:0] sq_trial;
  logic sq_ge;
  assign sq_trial = 62'(sqres_r) + 62'(sqbit_r);
  assign sq_ge = sqv_r >= sq_trial;

  // divide setup and one restoring step
  logic [30:0] m_val;
  logic signed [32:0] dnum;
  logic [31:0] dmag;
  logic [30:0] dtrial;
  logic dge;
  logic [17:0] sw_raw;
  assign m_val = sqres_r[30:0];
  assign dnum = (job_r == qtf_pkg::JOB_SWX)
              ? 33'(prod_r[qtf_pkg::P_WX]) + 33'(prod_r[qtf_pkg::P_YZ])
              : 33'(prod_r[qtf_pkg::P_WY]) - 33'(prod_r[qtf_pkg::P_ZX]);
  assign dmag = dnum[32] ? 32'(-dnum) : 32'(dnum);
  assign dtrial = {rem_r, dvd_r[45]};
  assign dge = dtrial >= m_val;
  assign sw_raw = 18'((32'(m_val) + 32'd8192) >> 14);

  // saturated signed quotient
  logic signed [15:0] qsat;
  always_comb begin
    if (dneg_r) begin
      qsat = (dvd_r > 46'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, dvd_r}));
    end else begin
      qsat = (dvd_r > 46'd32767) ? 16'sd32767 : $signed(dvd_r[15:0]);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qtf_pkg::S_IDLE:  if (in_valid) state_nxt = qtf_pkg::S_MUL;
      qtf_pkg::S_MUL:   if (cnt_r == 6'(qtf_pkg::MUL_SLOTS - 1)) state_nxt = qtf_pkg::S_CINIT;
      qtf_pkg::S_CINIT: state_nxt = qtf_pkg::S_CORD;
      qtf_pkg::S_CORD:  if (cnt_r == 6'(qtf_pkg::CORDIC_STEPS - 1)) state_nxt = qtf_pkg::S_CEND;
      qtf_pkg::S_CEND: begin
        priority case (job_r)
          qtf_pkg::JOB_PITCH: state_nxt = qtf_pkg::S_CINIT;
          qtf_pkg::JOB_YAW:   state_nxt = qtf_pkg::S_ASIN;
          default:            state_nxt = qtf_pkg::S_SWING;
        endcase
      end
      qtf_pkg::S_ASIN:  state_nxt = (asin_hi || asin_lo) ? qtf_pkg::S_SWING : qtf_pkg::S_SQRT;
      qtf_pkg::S_SQRT: begin
        if (cnt_r == 6'(qtf_pkg::SQRT_STEPS - 1)) begin
          state_nxt = (job_r == qtf_pkg::JOB_ASIN) ? qtf_pkg::S_CINIT : qtf_pkg::S_DINIT;
        end
      end
      qtf_pkg::S_SWING: state_nxt = degen ? qtf_pkg::S_FILT : qtf_pkg::S_SQRT;
      qtf_pkg::S_DINIT: state_nxt = qtf_pkg::S_DIV;
      qtf_pkg::S_DIV:   if (cnt_r == 6'(qtf_pkg::DIV_STEPS - 1)) state_nxt = qtf_pkg::S_DEND;
      qtf_pkg::S_DEND:  state_nxt = (job_r == qtf_pkg::JOB_SWX) ? qtf_pkg::S_DINIT
                                                                 : qtf_pkg::S_FILT;
      qtf_pkg::S_FILT:  if (cnt_r == 6'(qtf_pkg::FILT_SLOTS - 1)) state_nxt = qtf_pkg::S_OUT;
      qtf_pkg::S_OUT:   if (!out_valid_r || !out_stall) state_nxt = qtf_pkg::S_IDLE;
      default:          state_nxt = qtf_pkg::S_IDLE;
    endcase
  end

  // control state, filter memory, gain and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qtf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      gain_r <= qtf_pkg::GAIN_RESET;
      sp_r <= '0;
      sr_r <= '0;
      cnt_r <= '0;
      job_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) gain_r <= cfg_filter_gain;
      if (state_r == qtf_pkg::S_FILT && cnt_r == 6'd0) sp_r <= fwrap;
      if (state_r == qtf_pkg::S_FILT && cnt_r == 6'd1) sr_r <= fwrap;
      if (state_r == qtf_pkg::S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // step counter restarts on every state change
      if (state_nxt != state_r) cnt_r <= '0;
      else cnt_r <= cnt_r + 6'd1;
      // job tags of the shared units
      priority if (state_r == qtf_pkg::S_MUL) begin
        job_r <= qtf_pkg::JOB_PITCH;
      end else if (state_r == qtf_pkg::S_CEND && job_r == qtf_pkg::JOB_PITCH) begin
        job_r <= qtf_pkg::JOB_YAW;
      end else if (state_r == qtf_pkg::S_ASIN) begin
        job_r <= qtf_pkg::JOB_ASIN;
      end else if (state_r == qtf_pkg::S_SQRT && state_nxt == qtf_pkg::S_CINIT) begin
        job_r <= qtf_pkg::JOB_ROLL;
      end else if (state_r == qtf_pkg::S_SWING) begin
        job_r <= qtf_pkg::JOB_NORM;
      end else if (state_r == qtf_pkg::S_SQRT && state_nxt == qtf_pkg::S_DINIT) begin
        job_r <= qtf_pkg::JOB_SWX;
      end else if (state_r == qtf_pkg::S_DEND) begin
        job_r <= qtf_pkg::JOB_SWY;
      end else begin
        job_r <= job_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      qtf_pkg::S_IDLE: begin
        qw_r <= in_quat_w;
        qx_r <= in_quat_x;
        qy_r <= in_quat_y;
        qz_r <= in_quat_z;
      end
      qtf_pkg::S_MUL: begin
        if (cnt_r < 6'(qtf_pkg::P_SQ_HH)) begin
          prod_r[cnt_r[3:0]] <= mul_p[31:0];
        end else if (cnt_r == 6'(qtf_pkg::P_SQ_HH)) begin
          sq_r <= {1'b0, mul_p[27:0], 28'b0};
        end else if (cnt_r == 6'(qtf_pkg::P_SQ_HL)) begin
          sq_r <= sq_r + {13'b0, mul_p[28:0], 15'b0};
        end else begin
          sq_r <= sq_r + 57'(mul_p[27:0]);
        end
      end
      qtf_pkg::S_CINIT: begin
        cx_r <= cinit_x;
        cy_r <= cinit_y;
        acc_r <= cinit_acc;
        czero_r <= (cin_x == 40'sd0) && (cin_y == 40'sd0);
      end
      qtf_pkg::S_CORD: begin
        if (cy_r > 40'sd0) begin
          cx_r <= cx_r + cdx;
          cy_r <= cy_r - cdy;
          acc_r <= acc_r + ctab;
        end else begin
          cx_r <= cx_r - cdx;
          cy_r <= cy_r + cdy;
          acc_r <= acc_r - ctab;
        end
      end
      qtf_pkg::S_CEND: begin
        priority case (job_r)
          qtf_pkg::JOB_PITCH: ax_r <= angle;
          qtf_pkg::JOB_YAW:   az_r <= angle;
          default:            ay_r <= qtf_pkg::roll_shift(angle);
        endcase
      end
      qtf_pkg::S_ASIN: begin
        // sine term at magnitude one holds the angle at plus or minus 90 before the roll shift
        if (asin_hi) ay_r <= qtf_pkg::roll_shift(qtf_pkg::DEG90_Q7);
        else if (asin_lo) ay_r <= qtf_pkg::roll_shift(-qtf_pkg::DEG90_Q7);
        sqv_r <= 62'((57'd1 << 56) - sq_r);
        sqres_r <= '0;
        sqbit_r <= 61'd1 << 60;
      end
      qtf_pkg::S_SQRT: begin
        if (sq_ge) begin
          sqv_r <= sqv_r - sq_trial;
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
      end
      qtf_pkg::S_SWING: begin
        degen_r <= degen;
        if (degen) begin
          sw_r <= 16'sd16384;
          sx_r <= '0;
          sy_r <= '0;
        end
        sqv_r <= {2'b00, tw_sum[31:0], 28'b0};
        sqres_r <= '0;
        sqbit_r <= 61'd1 << 60;
      end
      qtf_pkg::S_DINIT: begin
        if (job_r == qtf_pkg::JOB_SWX) begin
          sw_r <= (sw_raw > 18'd32767) ? 16'sd32767 : $signed(sw_raw[15:0]);
        end
        dneg_r <= dnum[32];
        dvd_r <= {dmag, 14'b0} + 46'(m_val >> 1);
        rem_r <= '0;
      end
      qtf_pkg::S_DIV: begin
        rem_r <= dge ? 30'(dtrial - m_val) : dtrial[29:0];
        dvd_r <= {dvd_r[44:0], dge};
      end
      qtf_pkg::S_DEND: begin
        if (job_r == qtf_pkg::JOB_SWX) sx_r <= qsat;
        else sy_r <= qsat;
      end
      qtf_pkg::S_FILT: begin
        if (cnt_r == 6'd2) prad_r <= $signed(fround[31:16]);
        if (cnt_r == 6'd3) rrad_r <= 16'(-$signed(fround[31:16]));
      end
      qtf_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_pitch_deg <= ax_r;
          out_roll_deg <= ay_r;
          out_yaw_deg <= az_r;
          out_pitch_smoothed_deg <= sp_r;
          out_roll_smoothed_deg <= sr_r;
          out_pitch_smoothed_rad <= prad_r;
          out_roll_smoothed_rad <= rrad_r;
          out_swing_w <= sw_r;
          out_swing_x <= sx_r;
          out_swing_y <= sy_r;
          out_swing_degenerate <= degen_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != qtf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == qtf_pkg::S_MUL))
    else $error("accepted request did not start the product phase");

  a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sp_r <= 16'(qtf_pkg::DEG180)) && (sp_r >= -16'(qtf_pkg::DEG180)) &&
    (sr_r <= 16'(qtf_pkg::DEG180)) && (sr_r >= -16'(qtf_pkg::DEG180)))
    else $error("filtered angle left the wrap range");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == qtf_pkg::S_OUT))
    else $error("result shown without passing the output state");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qtf_pkg::S_CORD) |-> (cnt_r < 6'(qtf_pkg::CORDIC_STEPS)))
    else $error("cordic step count overran");

endmodule

`default_nettype wire
